### rtl/damap_pkg.sv
// Package for the deep attenuation map sampler.
// Holds the operation codes, configuration indices and the queued command type.
// No dependencies.
package damap_pkg;

    localparam logic [1:0] KIND_DEPTH_WR = 2'd0;
    localparam logic [1:0] KIND_ATTEN_WR = 2'd1;
    localparam logic [1:0] KIND_SAMPLE   = 2'd2;

    localparam logic [2:0] CFG_EXP_SPACING = 3'd0;
    localparam logic [2:0] CFG_LAYERS      = 3'd1;
    localparam logic [2:0] CFG_RECIP       = 3'd2;
    localparam logic [2:0] CFG_WIDTH       = 3'd3;
    localparam logic [2:0] CFG_HEIGHT      = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        OP_DEPTH_WR = 2'd0,
        OP_ATTEN_WR = 2'd1,
        OP_SAMPLE   = 2'd2
    } t_op;

    typedef struct packed {
        logic        exp_spacing;
        logic [3:0]  layers;
        logic [23:0] recip;
        logic [5:0]  width;
        logic [5:0]  height;
    } t_cfg;

    // one neighbour per bank; for writes nv marks the bank that is written
    typedef struct packed {
        logic [4:0]  rh;
        logic [4:0]  ch;
        logic        nv;
        logic [16:0] w;
    } t_nbr;

    typedef struct packed {
        t_op             op;
        t_nbr [3:0]      nbr;
        logic [2:0]      layer;
        logic [23:0]     depth;
        logic [47:0]     rgb;
    } t_cmd;

endpackage

### rtl/damap_front.sv
// Front end: classifies input transactions and works out the four neighbours.
// Depends on damap_pkg.
module damap_front #(
    parameter int MAP_WIDTH  = 32,
    parameter int MAP_HEIGHT = 32,
    parameter int MAX_LAYERS = 8
) (
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_kind,
    input  logic [4:0]          i_texel_column,
    input  logic [4:0]          i_texel_row,
    input  logic [2:0]          i_layer_index,
    input  logic [23:0]         i_surface_depth,
    input  logic [15:0]         i_atten_red_in,
    input  logic [15:0]         i_atten_green_in,
    input  logic [15:0]         i_atten_blue_in,
    input  logic [12:0]         i_pos_x,
    input  logic [12:0]         i_pos_y,
    input  logic [23:0]         i_sample_depth,
    input  damap_pkg::t_cfg     i_cfg,
    input  logic                i_full,
    output logic                o_push,
    output damap_pkg::t_cmd     o_cmd
);

    localparam logic [10:0] MW = 11'(MAP_WIDTH);
    localparam logic [10:0] MH = 11'(MAP_HEIGHT);

    logic [13:0] tx, ty;
    logic [5:0]  cp, rp;
    logic [7:0]  ax, ay;
    logic [10:0] weff, heff;
    logic        keep;
    logic        in_map;

    always_comb begin
        logic [1:0]  kb;
        logic        csec, rsec, cv, rv;
        logic [5:0]  col, row;
        logic [8:0]  wx, wy;
        tx = {1'b0, i_pos_x} + 14'd128;
        ty = {1'b0, i_pos_y} + 14'd128;
        cp = tx[13:8];
        rp = ty[13:8];
        ax = tx[7:0];
        ay = ty[7:0];
        weff = ({5'd0, i_cfg.width} > MW) ? MW : {5'd0, i_cfg.width};
        heff = ({5'd0, i_cfg.height} > MH) ? MH : {5'd0, i_cfg.height};
        in_map = ({6'd0, i_texel_column} < MW) && ({6'd0, i_texel_row} < MH);

        o_cmd = '0;
        o_cmd.layer = i_layer_index;
        o_cmd.rgb = {i_atten_red_in, i_atten_green_in, i_atten_blue_in};
        o_cmd.depth = (i_kind == damap_pkg::KIND_SAMPLE) ? i_sample_depth : i_surface_depth;
        keep = 1'b0;

        case (i_kind)
            damap_pkg::KIND_DEPTH_WR: begin
                o_cmd.op = damap_pkg::OP_DEPTH_WR;
                keep = in_map;
            end
            damap_pkg::KIND_ATTEN_WR: begin
                o_cmd.op = damap_pkg::OP_ATTEN_WR;
                keep = in_map && (int'(i_layer_index) < MAX_LAYERS);
            end
            damap_pkg::KIND_SAMPLE: begin
                o_cmd.op = damap_pkg::OP_SAMPLE;
                keep = 1'b1;
            end
            default: begin
                o_cmd.op = damap_pkg::OP_SAMPLE;
                keep = 1'b0;
            end
        endcase

        for (int k = 0; k < 4; k++) begin
            kb = 2'(k);
            if (i_kind == damap_pkg::KIND_SAMPLE) begin
                csec = (cp[0] == kb[0]);
                rsec = (rp[0] == kb[1]);
                col = csec ? cp : cp - 6'd1;
                row = rsec ? rp : rp - 6'd1;
                cv = csec ? ({5'd0, cp} < weff) : ((cp != 6'd0) && ({5'd0, cp} <= weff));
                rv = rsec ? ({5'd0, rp} < heff) : ((rp != 6'd0) && ({5'd0, rp} <= heff));
                wx = csec ? {1'b0, ax} : 9'd256 - {1'b0, ax};
                wy = rsec ? {1'b0, ay} : 9'd256 - {1'b0, ay};
                o_cmd.nbr[k].rh = row[5:1];
                o_cmd.nbr[k].ch = col[5:1];
                o_cmd.nbr[k].nv = cv && rv;
                o_cmd.nbr[k].w  = wx * wy;
            end else begin
                o_cmd.nbr[k].rh = {1'b0, i_texel_row[4:1]};
                o_cmd.nbr[k].ch = {1'b0, i_texel_column[4:1]};
                o_cmd.nbr[k].nv = (kb == {i_texel_row[0], i_texel_column[0]});
                o_cmd.nbr[k].w  = '0;
            end
        end
    end

    assign o_push  = i_valid && !i_full && keep;
    assign o_stall = i_full;

endmodule

### rtl/damap_queue.sv
// Short command queue between the front end and the back end.
// Depends on damap_pkg.
module damap_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  damap_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output damap_pkg::t_cmd o_cmd,
    output logic            o_have,
    output logic            o_full
);

    damap_pkg::t_cmd r_mem [damap_pkg::QUEUE_DEPTH];
    logic [damap_pkg::QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [damap_pkg::QUEUE_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (damap_pkg::QUEUE_AW+1)'(i_push)
                               - (damap_pkg::QUEUE_AW+1)'(i_pop);
        end
    end

    assign o_cmd  = r_mem[r_rptr];
    assign o_have = (r_count != '0);
    assign o_full = (r_count == (damap_pkg::QUEUE_AW+1)'(damap_pkg::QUEUE_DEPTH));

endmodule

### rtl/damap_back.sv
// Back end: banked depth and attenuation stores, layer search, interpolation, blend.
// Depends on damap_pkg.
module damap_back #(
    parameter int MAP_WIDTH  = 32,
    parameter int MAP_HEIGHT = 32,
    parameter int MAX_LAYERS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  damap_pkg::t_cfg i_cfg,
    input  logic            i_have,
    input  damap_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_atten_red_out,
    output logic [15:0]     o_atten_green_out,
    output logic [15:0]     o_atten_blue_out,
    output logic [23:0]     o_nearest_surface
);

    localparam int HALF_W      = (MAP_WIDTH + 1) / 2;
    localparam int HALF_H      = (MAP_HEIGHT + 1) / 2;
    localparam int BANK_TEXELS = HALF_W * HALF_H;
    localparam int AW          = (BANK_TEXELS > 1) ? $clog2(BANK_TEXELS) : 1;
    localparam int LW          = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int ATT_WORDS   = BANK_TEXELS * MAX_LAYERS;
    localparam int AAW         = (ATT_WORDS > 1) ? $clog2(ATT_WORDS) : 1;

    logic adv;
    logic [3:0] lcnt;

    logic [23:0] depth_mem [4][BANK_TEXELS];
    logic [47:0] atten_mem [4][ATT_WORDS];

    // stage 1: depth read
    logic             r_s1_v;
    damap_pkg::t_op   r_s1_op;
    logic [2:0]       r_s1_layer;
    logic [23:0]      r_s1_z;
    logic [47:0]      r_s1_rgb;
    logic [3:0]       r_s1_nv;
    logic [16:0]      r_s1_w [4];
    logic [AW-1:0]    r_s1_addr [4];
    logic [23:0]      r_s1_d [4];
    logic [AW-1:0]    n_addr [4];

    // stage 2: distance times reciprocal
    logic             r_s2_v;
    damap_pkg::t_op   r_s2_op;
    logic [2:0]       r_s2_layer;
    logic [47:0]      r_s2_rgb;
    logic [3:0]       r_s2_nv, r_s2_gt;
    logic [16:0]      r_s2_w [4];
    logic [AW-1:0]    r_s2_addr [4];
    logic [47:0]      r_s2_q [4];
    logic [23:0]      r_s2_near, n_near;

    // stage 3: leading one
    logic             r_s3_v;
    damap_pkg::t_op   r_s3_op;
    logic [2:0]       r_s3_layer;
    logic [47:0]      r_s3_rgb;
    logic [3:0]       r_s3_nv, r_s3_gt;
    logic [16:0]      r_s3_w [4];
    logic [AW-1:0]    r_s3_addr [4];
    logic [47:0]      r_s3_q [4];
    logic [48:0]      r_s3_u [4];
    logic [5:0]       r_s3_msb [4];
    logic [23:0]      r_s3_near;
    logic [48:0]      n_u [4];
    logic [5:0]       n_msb [4];

    // stage 4: layer, alpha, store addresses
    logic             r_s4_v;
    damap_pkg::t_op   r_s4_op;
    logic [47:0]      r_s4_rgb;
    logic [3:0]       r_s4_nv, r_s4_big, r_s4_zero, r_s4_zp;
    logic [16:0]      r_s4_w [4];
    logic [AAW-1:0]   r_s4_cur [4], r_s4_prev [4];
    logic [15:0]      r_s4_alpha [4];
    logic [23:0]      r_s4_near;
    logic [3:0]       n_big, n_zero, n_zp;
    logic [AAW-1:0]   n_cur [4], n_prev [4];
    logic [15:0]      n_alpha [4];

    // stage 5: attenuation read
    logic             r_s5_v;
    damap_pkg::t_op   r_s5_op;
    logic [3:0]       r_s5_big, r_s5_zero, r_s5_zp;
    logic [16:0]      r_s5_w [4];
    logic [47:0]      r_s5_cur [4], r_s5_prev [4];
    logic [15:0]      r_s5_alpha [4];
    logic [23:0]      r_s5_near;

    // stage 6: layer interpolation
    logic             r_s6_v;
    damap_pkg::t_op   r_s6_op;
    logic [16:0]      r_s6_w [4];
    logic [15:0]      r_s6_val [4][3];
    logic [23:0]      r_s6_near;
    logic [15:0]      n_val [4][3];

    // stage 7: weighting
    logic             r_s7_v;
    damap_pkg::t_op   r_s7_op;
    logic [32:0]      r_s7_p [4][3];
    logic [23:0]      r_s7_near;

    logic             r_o_valid;
    logic [15:0]      r_o_att [3];
    logic [23:0]      r_o_near;
    logic [15:0]      n_att [3];

    assign adv   = !r_o_valid || !i_stall;
    assign o_pop = i_have && adv;

    always_comb begin
        if (i_cfg.layers == 4'd0) begin
            lcnt = 4'd1;
        end else if (int'(i_cfg.layers) > MAX_LAYERS) begin
            lcnt = 4'(MAX_LAYERS);
        end else begin
            lcnt = i_cfg.layers;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_addr[k] = AW'(int'(i_cmd.nbr[k].rh) * HALF_W + int'(i_cmd.nbr[k].ch));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                if (o_pop && i_cmd.op == damap_pkg::OP_DEPTH_WR && i_cmd.nbr[k].nv) begin
                    depth_mem[k][n_addr[k]] <= i_cmd.depth;
                end
                r_s1_d[k] <= depth_mem[k][n_addr[k]];
            end
        end
    end

    always_comb begin
        n_near = 24'hFFFFFF;
        for (int k = 0; k < 4; k++) begin
            if (r_s1_nv[k] && r_s1_d[k] < n_near) begin
                n_near = r_s1_d[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_u[k] = {1'b0, r_s2_q[k]} + (49'd1 << 24);
            n_msb[k] = 6'd0;
            for (int i = 0; i < 49; i++) begin
                if (n_u[k][i]) begin
                    n_msb[k] = 6'(i);
                end
            end
        end
    end

    always_comb begin
        logic [23:0] lay;
        logic [48:0] sft;
        logic [5:0]  sh;
        logic [LW-1:0] ci;
        for (int k = 0; k < 4; k++) begin
            sh = r_s3_msb[k] - 6'd16;
            sft = r_s3_u[k] >> sh;
            if (i_cfg.exp_spacing) begin
                lay = {18'd0, r_s3_msb[k] - 6'd24};
                n_alpha[k] = sft[15:0];
            end else begin
                lay = r_s3_q[k][47:24];
                n_alpha[k] = r_s3_q[k][23:8];
            end
            n_big[k]  = (lay >= {20'd0, lcnt});
            n_zp[k]   = (lay == 24'd0);
            n_zero[k] = !(r_s3_gt[k] && r_s3_nv[k]);
            if (r_s3_op == damap_pkg::OP_ATTEN_WR) begin
                ci = LW'(r_s3_layer);
            end else if (n_big[k]) begin
                ci = LW'(lcnt - 4'd1);
            end else begin
                ci = LW'(lay);
            end
            n_cur[k]  = AAW'(int'(r_s3_addr[k]) * MAX_LAYERS + int'(ci));
            n_prev[k] = AAW'(int'(r_s3_addr[k]) * MAX_LAYERS + int'(LW'(ci - 1'b1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                if (r_s4_v && r_s4_op == damap_pkg::OP_ATTEN_WR && r_s4_nv[k]) begin
                    atten_mem[k][r_s4_cur[k]] <= r_s4_rgb;
                end
                r_s5_cur[k]  <= atten_mem[k][r_s4_cur[k]];
                r_s5_prev[k] <= atten_mem[k][r_s4_prev[k]];
            end
        end
    end

    always_comb begin
        logic [16:0] a17, na;
        logic [15:0] cv, pv;
        logic [33:0] pa, pb, s;
        for (int k = 0; k < 4; k++) begin
            a17 = {1'b0, r_s5_alpha[k]};
            na  = 17'h10000 - a17;
            for (int c = 0; c < 3; c++) begin
                cv = r_s5_cur[k][47-16*c -: 16];
                pv = r_s5_zp[k] ? 16'd0 : r_s5_prev[k][47-16*c -: 16];
                pa = na * pv;
                pb = a17 * cv;
                s  = pa + pb;
                if (r_s5_zero[k]) begin
                    n_val[k][c] = 16'd0;
                end else if (r_s5_big[k]) begin
                    n_val[k][c] = cv;
                end else begin
                    n_val[k][c] = s[31:16];
                end
            end
        end
    end

    always_comb begin
        logic [34:0] sum;
        for (int c = 0; c < 3; c++) begin
            sum = {2'b0, r_s7_p[0][c]} + {2'b0, r_s7_p[1][c]}
                + {2'b0, r_s7_p[2][c]} + {2'b0, r_s7_p[3][c]};
            n_att[c] = (|sum[34:32]) ? 16'hFFFF : sum[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op    <= i_cmd.op;
            r_s1_layer <= i_cmd.layer;
            r_s1_z     <= i_cmd.depth;
            r_s1_rgb   <= i_cmd.rgb;
            for (int k = 0; k < 4; k++) begin
                r_s1_nv[k]   <= i_cmd.nbr[k].nv;
                r_s1_w[k]    <= i_cmd.nbr[k].w;
                r_s1_addr[k] <= n_addr[k];
            end

            r_s2_op    <= r_s1_op;
            r_s2_layer <= r_s1_layer;
            r_s2_rgb   <= r_s1_rgb;
            r_s2_nv    <= r_s1_nv;
            r_s2_near  <= n_near;
            for (int k = 0; k < 4; k++) begin
                r_s2_w[k]    <= r_s1_w[k];
                r_s2_addr[k] <= r_s1_addr[k];
                r_s2_gt[k]   <= (r_s1_z > r_s1_d[k]);
                r_s2_q[k]    <= (r_s1_z - r_s1_d[k]) * i_cfg.recip;
            end

            r_s3_op    <= r_s2_op;
            r_s3_layer <= r_s2_layer;
            r_s3_rgb   <= r_s2_rgb;
            r_s3_nv    <= r_s2_nv;
            r_s3_gt    <= r_s2_gt;
            r_s3_near  <= r_s2_near;
            for (int k = 0; k < 4; k++) begin
                r_s3_w[k]    <= r_s2_w[k];
                r_s3_addr[k] <= r_s2_addr[k];
                r_s3_q[k]    <= r_s2_q[k];
                r_s3_u[k]    <= n_u[k];
                r_s3_msb[k]  <= n_msb[k];
            end

            r_s4_op   <= r_s3_op;
            r_s4_rgb  <= r_s3_rgb;
            r_s4_nv   <= r_s3_nv;
            r_s4_big  <= n_big;
            r_s4_zero <= n_zero;
            r_s4_zp   <= n_zp;
            r_s4_near <= r_s3_near;
            for (int k = 0; k < 4; k++) begin
                r_s4_w[k]     <= r_s3_w[k];
                r_s4_cur[k]   <= n_cur[k];
                r_s4_prev[k]  <= n_prev[k];
                r_s4_alpha[k] <= n_alpha[k];
            end

            r_s5_op   <= r_s4_op;
            r_s5_big  <= r_s4_big;
            r_s5_zero <= r_s4_zero;
            r_s5_zp   <= r_s4_zp;
            r_s5_near <= r_s4_near;
            for (int k = 0; k < 4; k++) begin
                r_s5_w[k]     <= r_s4_w[k];
                r_s5_alpha[k] <= r_s4_alpha[k];
            end

            r_s6_op   <= r_s5_op;
            r_s6_near <= r_s5_near;
            for (int k = 0; k < 4; k++) begin
                r_s6_w[k] <= r_s5_w[k];
                for (int c = 0; c < 3; c++) begin
                    r_s6_val[k][c] <= n_val[k][c];
                end
            end

            r_s7_op   <= r_s6_op;
            r_s7_near <= r_s6_near;
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s7_p[k][c] <= r_s6_w[k] * r_s6_val[k][c];
                end
            end

            r_o_near <= r_s7_near;
            for (int c = 0; c < 3; c++) begin
                r_o_att[c] <= n_att[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_s5_v    <= 1'b0;
            r_s6_v    <= 1'b0;
            r_s7_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_s1_v    <= o_pop;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            r_s5_v    <= r_s4_v;
            r_s6_v    <= r_s5_v;
            r_s7_v    <= r_s6_v;
            r_o_valid <= r_s7_v && (r_s7_op == damap_pkg::OP_SAMPLE);
        end
    end

    assign o_valid           = r_o_valid;
    assign o_atten_red_out   = r_o_att[0];
    assign o_atten_green_out = r_o_att[1];
    assign o_atten_blue_out  = r_o_att[2];
    assign o_nearest_surface = r_o_near;

endmodule

### rtl/deep_attenuation_map_sampler.sv
// Top level of the deep attenuation map sampler: configuration registers,
// front end, command queue and back end. Depends on damap_pkg and the damap_* modules.
//
// Takes one transaction per clock (depth write, attenuation write or sample) unless
// o_stall is high because the queue is full, and returns one result per sample. The
// store is split into four banks by row and column parity so the four neighbours of
// a sample are read in the same cycle; a result passes through the back-end stage
// registers and the output register after its command leaves the four-entry queue,
// and the whole back end holds while a valid result is stalled. Both stores power
// up uninitialised and have no clearing pass: texels must be written before
// they are sampled. Writes take effect in transaction order with samples.
module deep_attenuation_map_sampler #(
    parameter int MAP_WIDTH  = 32,
    parameter int MAP_HEIGHT = 32,
    parameter int MAX_LAYERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [4:0]  i_texel_column,
    input  logic [4:0]  i_texel_row,
    input  logic [2:0]  i_layer_index,
    input  logic [23:0] i_surface_depth,
    input  logic [15:0] i_atten_red_in,
    input  logic [15:0] i_atten_green_in,
    input  logic [15:0] i_atten_blue_in,
    input  logic [12:0] i_pos_x,
    input  logic [12:0] i_pos_y,
    input  logic [23:0] i_sample_depth,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_atten_red_out,
    output logic [15:0] o_atten_green_out,
    output logic [15:0] o_atten_blue_out,
    output logic [23:0] o_nearest_surface,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    damap_pkg::t_cfg r_cfg;
    damap_pkg::t_cmd front_cmd, queue_cmd;
    logic push, pop, have, full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_spacing <= 1'b0;
            r_cfg.layers      <= 4'd8;
            r_cfg.recip       <= 24'd65536;
            r_cfg.width       <= 6'd32;
            r_cfg.height      <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                damap_pkg::CFG_EXP_SPACING: r_cfg.exp_spacing <= i_cfg_data[0];
                damap_pkg::CFG_LAYERS:      r_cfg.layers      <= i_cfg_data[3:0];
                damap_pkg::CFG_RECIP:       r_cfg.recip       <= i_cfg_data;
                damap_pkg::CFG_WIDTH:       r_cfg.width       <= i_cfg_data[5:0];
                damap_pkg::CFG_HEIGHT:      r_cfg.height      <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    damap_front #(
        .MAP_WIDTH (MAP_WIDTH),
        .MAP_HEIGHT(MAP_HEIGHT),
        .MAX_LAYERS(MAX_LAYERS)
    ) u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_texel_column  (i_texel_column),
        .i_texel_row     (i_texel_row),
        .i_layer_index   (i_layer_index),
        .i_surface_depth (i_surface_depth),
        .i_atten_red_in  (i_atten_red_in),
        .i_atten_green_in(i_atten_green_in),
        .i_atten_blue_in (i_atten_blue_in),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_sample_depth  (i_sample_depth),
        .i_cfg           (r_cfg),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    damap_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .i_pop  (pop),
        .o_cmd  (queue_cmd),
        .o_have (have),
        .o_full (full)
    );

    damap_back #(
        .MAP_WIDTH (MAP_WIDTH),
        .MAP_HEIGHT(MAP_HEIGHT),
        .MAX_LAYERS(MAX_LAYERS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_have           (have),
        .i_cmd            (queue_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_atten_red_out  (o_atten_red_out),
        .o_atten_green_out(o_atten_green_out),
        .o_atten_blue_out (o_atten_blue_out),
        .o_nearest_surface(o_nearest_surface)
    );

endmodule

### rtl/damap_checker.sv
// Port-level checks for the deep attenuation map sampler, bound to the top level.
// No package dependency.
module damap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_atten_red_out,
    input logic [15:0] o_atten_green_out,
    input logic [15:0] o_atten_blue_out,
    input logic [23:0] o_nearest_surface
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_atten_red_out)
            && $stable(o_nearest_surface))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_nearest_surface == 24'hFFFFFF |->
            o_atten_red_out == 16'd0 && o_atten_green_out == 16'd0
            && o_atten_blue_out == 16'd0)
        else $error("attenuation without any neighbour in the map");

endmodule

bind deep_attenuation_map_sampler damap_checker u_damap_checker (.*);
